### rtl/rfc3339_timestamp_to_epoch_unit_assert.svh
// Assertion macros used by the timestamp parser controller.
`ifndef RFC3339_TIMESTAMP_TO_EPOCH_UNIT_ASSERT_SVH
`define RFC3339_TIMESTAMP_TO_EPOCH_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define R2E_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define R2E_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/r2e_pkg.sv
// Types, character constants and helper functions of the timestamp parser.
package r2e_pkg;

	// ASCII characters recognized by the parser.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_T     = 8'h54;

	// Header layout and offset buffer size.
	localparam logic [4:0] HDR_LAST_POS = 5'd18;
	localparam int unsigned OFF_SLOTS   = 5;

	// Last value of the compute step counter; the arithmetic pipeline has settled by then.
	localparam logic [2:0] CALC_LAST = 3'd5;

	// Controller states: parse phases followed by the compute sequence.
	typedef enum logic [2:0] {
		ST_LEAD,
		ST_HEAD,
		ST_DECIDE,
		ST_FRAC,
		ST_OFFSET,
		ST_DONE,
		ST_CALC,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic hdr_en;
		logic set_sign;
		logic off_en;
		logic calc_en;
		logic load_out;
		logic clear;
		logic fmt_ok;
		logic use_off;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic ws;
		logic digit;
		logic dot;
		logic sign;
		logic hdr_last;
	} stat_t;

	// Space, tab, LF, VT, FF and CR count as whitespace.
	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// Two-digit decimal value, or zero if either character is not a digit.
	function automatic logic [6:0] two_digits(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] da;
		logic [7:0] db;
		da = a - CH_ZERO;
		db = b - CH_ZERO;
		if (!is_digit(a) || !is_digit(b)) begin
			return 7'd0;
		end
		return 7'(da[3:0] * 7'd10) + 7'(db[3:0]);
	endfunction

endpackage

### rtl/r2e_if.sv
// Valid/ready channel interfaces for text words and result words.
interface r2e_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;

	modport source (output valid, output text_byte, output last_byte, input ready);
	modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface r2e_out_if;
	logic               valid;
	logic               ready;
	logic               status;
	logic signed [38:0] epoch_seconds;

	modport source (output valid, output status, output epoch_seconds, input ready);
	modport sink (input valid, input status, input epoch_seconds, output ready);
endinterface

### rtl/rfc3339_timestamp_to_epoch_unit.sv
// Non-final text words are taken as soon as offered; after the final word
// the controller runs the days-from-civil pipeline, then loads the result
// register once any earlier result word is taken; no word is taken in between.
// Words of the next timestamp wait until this result has been loaded.
// Reset: arst_n clears the parse state, sequencer and result valid at once.
module rfc3339_timestamp_to_epoch_unit
	import r2e_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	r2e_in_if.sink   text,
	r2e_out_if.source result
);

	cmd_t  cmd;
	stat_t stat;

	// Sequencing of parse phases and compute steps.
	r2e_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (text.valid),
		.in_last   (text.last_byte),
		.out_ready (result.ready),
		.stat      (stat),
		.in_ready  (text.ready),
		.out_valid (result.valid),
		.cmd       (cmd)
	);

	// Field capture and epoch arithmetic.
	r2e_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_byte     (text.text_byte),
		.cmd           (cmd),
		.stat          (stat),
		.status        (result.status),
		.epoch_seconds (result.epoch_seconds)
	);

endmodule

### rtl/r2e_dpath.sv
// Datapath: field accumulators, offset buffer, epoch arithmetic and result register.
module r2e_dpath
	import r2e_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         text_byte,
	input  cmd_t               cmd,
	output stat_t              stat,
	output logic               status,
	output logic signed [38:0] epoch_seconds
);

	// Parse state.
	logic [4:0]  pos_q;
	logic        hdr_failed_q;
	logic [13:0] year_q;
	logic [6:0]  month_q;
	logic [6:0]  day_q;
	logic [6:0]  hour_q;
	logic [6:0]  minute_q;
	logic [6:0]  second_q;
	logic        neg_q;
	logic [7:0]  off_chars_q [OFF_SLOTS];
	logic [2:0]  off_cnt_q;
	logic [2:0]  pend_q;

	// Arithmetic pipeline.
	logic signed [14:0] y_s1;
	logic [14:0]        x_s1;
	logic [18:0]        hms_s1;
	logic signed [19:0] off_s1;
	logic signed [6:0]  era_s2;
	logic [12:0]        q5_s2;
	logic [8:0]         yoe_s3;
	logic signed [12:0] doy_s3;
	logic signed [18:0] doe_s4;
	logic signed [23:0] days_s5;
	logic signed [40:0] prod_s6;

	// Result register.
	logic               status_q;
	logic signed [38:0] epoch_q;

	logic       dig_ok;
	logic [3:0] dig_val;
	logic [7:0] dig_raw;

	// Character class of the incoming word.
	always_comb begin
		dig_raw       = text_byte - CH_ZERO;
		dig_val       = dig_raw[3:0];
		dig_ok        = is_digit(text_byte);
		stat.ws       = is_ws(text_byte);
		stat.digit    = dig_ok;
		stat.dot      = (text_byte == CH_DOT);
		stat.sign     = (text_byte == CH_PLUS) || (text_byte == CH_DASH);
		stat.hdr_last = (pos_q == HDR_LAST_POS);
	end

	// Header fields: digits accumulate, separators are checked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			hdr_failed_q <= 1'b0;
			year_q       <= '0;
			month_q      <= '0;
			day_q        <= '0;
			hour_q       <= '0;
			minute_q     <= '0;
			second_q     <= '0;
		end else if (cmd.clear) begin
			pos_q        <= '0;
			hdr_failed_q <= 1'b0;
			year_q       <= '0;
			month_q      <= '0;
			day_q        <= '0;
			hour_q       <= '0;
			minute_q     <= '0;
			second_q     <= '0;
		end else if (cmd.hdr_en) begin
			pos_q <= pos_q + 5'd1;
			unique case (pos_q)
				5'd0, 5'd1, 5'd2, 5'd3: begin
					if (dig_ok) year_q <= 14'(year_q * 14'd10) + 14'(dig_val);
					else hdr_failed_q <= 1'b1;
				end
				5'd5, 5'd6: begin
					if (dig_ok) month_q <= 7'(month_q * 7'd10) + 7'(dig_val);
					else hdr_failed_q <= 1'b1;
				end
				5'd8, 5'd9: begin
					if (dig_ok) day_q <= 7'(day_q * 7'd10) + 7'(dig_val);
					else hdr_failed_q <= 1'b1;
				end
				5'd11, 5'd12: begin
					if (dig_ok) hour_q <= 7'(hour_q * 7'd10) + 7'(dig_val);
					else hdr_failed_q <= 1'b1;
				end
				5'd14, 5'd15: begin
					if (dig_ok) minute_q <= 7'(minute_q * 7'd10) + 7'(dig_val);
					else hdr_failed_q <= 1'b1;
				end
				5'd17, 5'd18: begin
					if (dig_ok) second_q <= 7'(second_q * 7'd10) + 7'(dig_val);
					else hdr_failed_q <= 1'b1;
				end
				5'd4, 5'd7: begin
					if (text_byte != CH_DASH) hdr_failed_q <= 1'b1;
				end
				5'd10: begin
					if ((text_byte != CH_T) && (text_byte != CH_SPACE)) hdr_failed_q <= 1'b1;
				end
				default: begin
					if (text_byte != CH_COLON) hdr_failed_q <= 1'b1;
				end
			endcase
		end
	end

	// Offset buffer: whitespace is held back and only stored once a later
	// non-whitespace character shows it is not trailing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q     <= 1'b0;
			off_cnt_q <= '0;
			pend_q    <= '0;
		end else if (cmd.clear) begin
			neg_q     <= 1'b0;
			off_cnt_q <= '0;
			pend_q    <= '0;
		end else begin
			if (cmd.set_sign) neg_q <= (text_byte == CH_DASH);
			if (cmd.off_en) begin
				if (stat.ws) begin
					if (pend_q < 3'(OFF_SLOTS)) pend_q <= pend_q + 3'd1;
				end else begin
					pend_q <= '0;
					if ({1'b0, off_cnt_q} + {1'b0, pend_q} >= 4'(OFF_SLOTS))
						off_cnt_q <= 3'(OFF_SLOTS);
					else
						off_cnt_q <= off_cnt_q + pend_q + 3'd1;
				end
			end
		end
	end

	// Offset character slots carry no reset; the count qualifies them.
	always_ff @(posedge clk) begin
		if (cmd.off_en && !stat.ws) begin
			for (int i = 0; i < OFF_SLOTS; i++) begin
				if ((4'(i) >= {1'b0, off_cnt_q}) &&
				    (4'(i) < {1'b0, off_cnt_q} + {1'b0, pend_q}))
					off_chars_q[i] <= CH_SPACE;
				else if (4'(i) == {1'b0, off_cnt_q} + {1'b0, pend_q})
					off_chars_q[i] <= text_byte;
			end
		end
	end

	logic       le2;
	logic [6:0] mp;
	logic [6:0] oh;
	logic [6:0] om;
	logic [18:0] off_mag;
	logic        off_apply;

	// First stage inputs: year shift flag, shifted month and offset.
	always_comb begin
		le2       = (month_q <= 7'd2);
		mp        = le2 ? (month_q + 7'd9) : (month_q - 7'd3);
		oh        = two_digits(off_chars_q[0], off_chars_q[1]);
		om        = (off_cnt_q >= 3'd5) ? two_digits(off_chars_q[3], off_chars_q[4]) : 7'd0;
		off_mag   = 19'(19'(oh) * 19'd3600) + 19'(19'(om) * 19'd60);
		off_apply = cmd.use_off && (off_cnt_q >= 3'd4);
	end

	logic [26:0]        era_prod;
	logic [30:0]        q5_prod;
	logic signed [15:0] yoe_full;
	logic [17:0]        yoe365;
	logic [1:0]         cent;
	logic [18:0]        doe_u;

	// Reciprocal multiplies and day-count terms.
	always_comb begin
		era_prod = 27'(y_s1[13:0]) * 27'd5243;
		q5_prod  = 31'(x_s1) * 31'd52429;
		yoe_full = 16'(y_s1) - 16'(16'(era_s2) * 16'sd400);
		yoe365   = 18'(yoe_s3) * 18'd365;
		if (yoe_s3 >= 9'd300) cent = 2'd3;
		else if (yoe_s3 >= 9'd200) cent = 2'd2;
		else if (yoe_s3 >= 9'd100) cent = 2'd1;
		else cent = 2'd0;
		doe_u = {1'b0, yoe365} + 19'(yoe_s3[8:2]) - 19'(cent);
	end

	// Days-from-civil pipeline; inputs hold still while it runs.
	always_ff @(posedge clk) begin
		if (cmd.calc_en) begin
			y_s1    <= $signed({1'b0, year_q} - {14'd0, le2});
			x_s1    <= 15'({8'd0, mp} * 15'd153) + 15'd2;
			hms_s1  <= 19'(19'(hour_q) * 19'd3600) + 19'(19'(minute_q) * 19'd60)
			           + 19'(second_q);
			off_s1  <= !off_apply ? 20'sd0 :
			           neg_q ? -$signed({1'b0, off_mag}) : $signed({1'b0, off_mag});
			era_s2  <= y_s1[14] ? -7'sd1 : $signed({1'b0, era_prod[26:21]});
			q5_s2   <= q5_prod[30:18];
			yoe_s3  <= yoe_full[8:0];
			doy_s3  <= $signed(q5_s2 + {6'd0, day_q} - 13'd1);
			doe_s4  <= $signed(doe_u) + 19'(doy_s3);
			days_s5 <= 24'(era_s2) * 24'sd146097 + 24'(doe_s4) - 24'sd719468;
			prod_s6 <= 41'(days_s5) * 41'sd86400;
		end
	end

	logic signed [40:0] secs;

	// Final sum: day seconds plus time of day minus offset.
	assign secs = prod_s6 + 41'($signed({1'b0, hms_s1})) - 41'(off_s1);

	// Result register, loaded when the result word is handed out.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_q <= !(cmd.fmt_ok && !hdr_failed_q);
			epoch_q  <= (cmd.fmt_ok && !hdr_failed_q) ? secs[38:0] : 39'sd0;
		end
	end

	assign status        = status_q;
	assign epoch_seconds = epoch_q;

endmodule

### rtl/r2e_ctrl.sv
// Controller: parse phase state machine and compute sequencer.
module r2e_ctrl
	import r2e_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_last,
	input  logic  out_ready,
	input  stat_t stat,
	output logic  in_ready,
	output logic  out_valid,
	output cmd_t  cmd
);

	`include "rfc3339_timestamp_to_epoch_unit_assert.svh"

	state_t     state_q;
	state_t     state_d;
	state_t     parse_d;
	logic [2:0] calc_cnt_q;
	logic       fmt_ok_q;
	logic       use_off_q;
	logic       out_valid_q;
	logic       in_acc;

	// State, counter, format flags and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LEAD;
			calc_cnt_q  <= '0;
			fmt_ok_q    <= 1'b0;
			use_off_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			calc_cnt_q <= (state_q == ST_CALC) ? calc_cnt_q + 3'd1 : 3'd0;
			if (in_acc && in_last) begin
				fmt_ok_q  <= (parse_d == ST_DECIDE) || (parse_d == ST_FRAC) ||
				             (parse_d == ST_OFFSET) || (parse_d == ST_DONE);
				use_off_q <= (parse_d == ST_OFFSET);
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		in_ready    = (state_q != ST_CALC) && (state_q != ST_EMIT);
		in_acc      = in_valid && in_ready;
		cmd         = '0;
		cmd.fmt_ok  = fmt_ok_q;
		cmd.use_off = use_off_q;
		parse_d     = state_q;
		unique case (state_q)
			ST_LEAD: begin
				if (in_acc && !stat.ws) begin
					cmd.hdr_en = 1'b1;
					parse_d    = ST_HEAD;
				end
			end
			ST_HEAD: begin
				if (in_acc) begin
					cmd.hdr_en = 1'b1;
					if (stat.hdr_last) parse_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (in_acc) begin
					if (stat.dot) begin
						parse_d = ST_FRAC;
					end else if (stat.sign) begin
						cmd.set_sign = 1'b1;
						parse_d      = ST_OFFSET;
					end else begin
						parse_d = ST_DONE;
					end
				end
			end
			ST_FRAC: begin
				if (in_acc && !stat.digit) begin
					if (stat.sign) begin
						cmd.set_sign = 1'b1;
						parse_d      = ST_OFFSET;
					end else begin
						parse_d = ST_DONE;
					end
				end
			end
			ST_OFFSET: begin
				cmd.off_en = in_acc;
			end
			ST_DONE: begin
			end
			ST_CALC: begin
				cmd.calc_en = 1'b1;
				if (calc_cnt_q == CALC_LAST) parse_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					cmd.clear    = 1'b1;
					parse_d      = ST_LEAD;
				end
			end
		endcase
		state_d = (in_acc && in_last) ? ST_CALC : parse_d;
	end

	assign out_valid = out_valid_q;

	// A final word always starts the compute sequence from its first step.
	`R2E_ASSERT_NXT(a_last_starts_calc, in_acc && in_last,
		state_q == ST_CALC && calc_cnt_q == 3'd0, "final word did not start compute")
	// The compute sequence runs its full length without interruption.
	`R2E_ASSERT_NXT(a_calc_runs, state_q == ST_CALC && calc_cnt_q != CALC_LAST,
		state_q == ST_CALC, "compute sequence cut short")
	// Handing out a result returns to whitespace skipping with a valid word.
	`R2E_ASSERT_NXT(a_emit_done, state_q == ST_EMIT && cmd.load_out,
		state_q == ST_LEAD && out_valid_q, "result hand-off incomplete")

endmodule

### test/tb_rfc3339_timestamp_to_epoch_unit.sv
// Testbench for the streaming timestamp parser that yields signed Unix seconds.
`timescale 1ns / 1ps

module tb_rfc3339_timestamp_to_epoch_unit;
	import r2e_pkg::*;

	// Characters that the package does not name.
	localparam logic [7:0] CH_Z = 8'h5A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam longint SECS_PER_DAY = 86400;
	localparam longint SECS_PER_HOUR = 3600;
	localparam longint DAYS_PER_ERA = 146097;
	localparam longint EPOCH_DAY_SHIFT = 719468;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 16;

	// One timestamp result as the block reports it.
	typedef struct packed {
		logic        status;
		logic [38:0] epoch;
	} epoch_result_t;

	// Parses the text word by word alongside the block and checks its results.
	class epoch_scoreboard;
		state_t        phase;
		int unsigned   pos;
		logic          hdr_bad;
		logic [13:0]   year;
		logic [6:0]    month;
		logic [6:0]    day;
		logic [6:0]    hour;
		logic [6:0]    minute;
		logic [6:0]    second;
		logic          off_neg;
		logic [7:0]    off_ch [5];
		int unsigned   off_n;
		int unsigned   blank_pend;
		epoch_result_t expected_epochs[$];
		int unsigned   errors;
		int unsigned   results_ok;
		int unsigned   results_bad;

		function new();
			errors = 0;
			results_ok = 0;
			results_bad = 0;
			start_over();
		endfunction

		function void start_over();
			phase = ST_LEAD;
			pos = 0;
			hdr_bad = 1'b0;
			year = '0;
			month = '0;
			day = '0;
			hour = '0;
			minute = '0;
			second = '0;
			off_neg = 1'b0;
			foreach (off_ch[i]) off_ch[i] = 8'h00;
			off_n = 0;
			blank_pend = 0;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c inside {CH_SPACE, [CH_TAB:CH_CR]};
		endfunction

		function bit is_num(logic [7:0] c);
			return c inside {[CH_ZERO:CH_NINE]};
		endfunction

		// Appends a decimal digit, truncated to 14 bits; callers narrow it further.
		function logic [13:0] shift_in(logic [13:0] acc, logic [7:0] c);
			if (!is_num(c)) begin
				hdr_bad = 1'b1;
				return acc;
			end
			return 14'(acc * 10 + (c - CH_ZERO));
		endfunction

		function void take_header_char(logic [7:0] c);
			case (pos)
				0, 1, 2, 3: year = shift_in(year, c);
				5, 6: month = 7'(shift_in(14'(month), c));
				8, 9: day = 7'(shift_in(14'(day), c));
				11, 12: hour = 7'(shift_in(14'(hour), c));
				14, 15: minute = 7'(shift_in(14'(minute), c));
				17, 18: second = 7'(shift_in(14'(second), c));
				4, 7: if (c != CH_DASH) hdr_bad = 1'b1;
				10: if (c != CH_T && c != CH_SPACE) hdr_bad = 1'b1;
				default: if (c != CH_COLON) hdr_bad = 1'b1;
			endcase
			pos++;
			if (pos >= 19) begin
				pos = 19;
				phase = ST_DECIDE;
			end
		endfunction

		function void take_after_header(logic [7:0] c, bit dot_ok);
			if (dot_ok && c == CH_DOT) begin
				phase = ST_FRAC;
			end else if (c == CH_PLUS || c == CH_DASH) begin
				off_neg = (c == CH_DASH);
				phase = ST_OFFSET;
			end else begin
				phase = ST_DONE;
			end
		endfunction

		// Blanks inside the offset are held back and only kept if more text follows.
		function void take_offset_char(logic [7:0] c);
			if (is_blank(c)) begin
				if (blank_pend < 5) blank_pend++;
				return;
			end
			while (blank_pend > 0 && off_n < 5) begin
				off_ch[off_n] = CH_SPACE;
				off_n++;
				blank_pend--;
			end
			blank_pend = 0;
			if (off_n < 5) begin
				off_ch[off_n] = c;
				off_n++;
			end
		endfunction

		function longint offset_pair(logic [7:0] a, logic [7:0] b);
			longint hi;
			longint lo;
			if (!is_num(a) || !is_num(b)) return 0;
			hi = a - CH_ZERO;
			lo = b - CH_ZERO;
			return hi * 10 + lo;
		endfunction

		// Days since 1970-01-01 for a proleptic Gregorian date, fields unchecked.
		function longint civil_to_days(longint y, longint m, longint d);
			longint era;
			longint yoe;
			longint doy;
			longint doe;
			if (m <= 2) y = y - 1;
			era = (y >= 0 ? y : y - 399) / 400;
			yoe = y - era * 400;
			doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
			doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
			return era * DAYS_PER_ERA + doe - EPOCH_DAY_SHIFT;
		endfunction

		// Called for every text word the block accepts.
		function void note_word(logic [7:0] c, logic last);
			bit            ok;
			longint        secs;
			longint        ofs;
			longint        y;
			longint        m;
			longint        d;
			longint        h;
			longint        mn;
			longint        s;
			epoch_result_t item;
			case (phase)
				ST_LEAD: begin
					if (!is_blank(c)) begin
						phase = ST_HEAD;
						take_header_char(c);
					end
				end
				ST_HEAD: take_header_char(c);
				ST_DECIDE: take_after_header(c, 1'b1);
				ST_FRAC: if (!is_num(c)) take_after_header(c, 1'b0);
				ST_OFFSET: take_offset_char(c);
				default: ;
			endcase
			if (!last) return;
			ok = (phase inside {ST_DECIDE, ST_FRAC, ST_OFFSET, ST_DONE}) && !hdr_bad;
			item.status = !ok;
			item.epoch = '0;
			if (ok) begin
				y = year;
				m = month;
				d = day;
				h = hour;
				mn = minute;
				s = second;
				secs = civil_to_days(y, m, d) * SECS_PER_DAY + h * SECS_PER_HOUR + mn * 60 + s;
				if (phase == ST_OFFSET && off_n >= 4) begin
					ofs = offset_pair(off_ch[0], off_ch[1]) * SECS_PER_HOUR;
					if (off_n >= 5) ofs = ofs + offset_pair(off_ch[3], off_ch[4]) * 60;
					if (off_neg) ofs = -ofs;
					secs = secs - ofs;
				end
				item.epoch = secs[38:0];
			end
			expected_epochs.push_back(item);
			start_over();
		endfunction

		task report_mismatch(string msg);
			$display("Mismatch: %s", msg);
			errors++;
		endtask

		// Called for every result word the block hands over.
		task check_result(logic status, logic [38:0] epoch);
			epoch_result_t want;
			if (status) results_bad++;
			else results_ok++;
			if (expected_epochs.size() == 0) begin
				report_mismatch($sformatf("result status %0b seconds %0d with no timestamp pending",
					status, $signed(epoch)));
				return;
			end
			want = expected_epochs.pop_front();
			if (status !== want.status) begin
				report_mismatch($sformatf("status got %0b, expected %0b", status, want.status));
			end
			if (epoch !== want.epoch) begin
				report_mismatch($sformatf("epoch_seconds got %0d, expected %0d",
					$signed(epoch), $signed(want.epoch)));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	r2e_in_if text_if ();
	r2e_out_if result_if ();

	rfc3339_timestamp_to_epoch_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.result (result_if)
	);

	epoch_scoreboard sb;
	logic [7:0]      text_buf[$];
	int              send_idle_pct;
	int              recv_idle_pct;
	int              words_sent;
	int              texts_sent;
	bit              hold_pending;
	int              hold_left;
	int              quiet_cycles;

	// Clock.
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Receiver: checks each accepted result word, then picks the next ready.
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			sb.check_result(result_if.status, result_if.epoch_seconds);
		end
		if (hold_pending && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_pending = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((text_if.valid && text_if.ready) || (result_if.valid && result_if.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Offers one text word, with random idle cycles first, and waits for it to go in.
	task automatic send_word(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			text_if.valid <= 1'b0;
			@(posedge clk);
		end
		text_if.valid <= 1'b1;
		text_if.text_byte <= c;
		text_if.last_byte <= last;
		@(posedge clk);
		while (!text_if.ready) @(posedge clk);
		sb.note_word(c, last);
		words_sent++;
	endtask

	task automatic send_text();
		foreach (text_buf[i]) send_word(text_buf[i], i == text_buf.size() - 1);
		texts_sent++;
	endtask

	task automatic send_string(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
		send_text();
	endtask

	function automatic logic [7:0] pick_blank();
		int k;
		k = $urandom_range(5);
		return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
	endfunction

	function automatic logic [7:0] pick_digit();
		return 8'(CH_ZERO + $urandom_range(9));
	endfunction

	function automatic int rand_field(int lo, int hi);
		return ($urandom_range(3) == 0) ? $urandom_range(99) : $urandom_range(hi, lo);
	endfunction

	task automatic put_num(input int v, input int n);
		int div;
		div = 1;
		repeat (n - 1) div = div * 10;
		repeat (n) begin
			text_buf.push_back(8'(CH_ZERO + (v / div) % 10));
			div = div / 10;
		end
	endtask

	// Sign, then up to five offset characters, some damaged or split by blanks, sometimes with junk after.
	task automatic put_offset();
		logic [7:0] part[5];
		int         keep;
		text_buf.push_back($urandom_range(1) ? CH_PLUS : CH_DASH);
		foreach (part[i]) begin
			if (i == 2) part[i] = ($urandom_range(5) == 0) ? 8'($urandom_range(255)) : CH_COLON;
			else part[i] = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : pick_digit();
		end
		keep = ($urandom_range(3) == 0) ? $urandom_range(5) : 5;
		for (int i = 0; i < keep; i++) begin
			if ($urandom_range(6) == 0) text_buf.push_back(pick_blank());
			text_buf.push_back(part[i]);
		end
		if ($urandom_range(5) == 0) begin
			repeat ($urandom_range(3, 1)) text_buf.push_back(8'($urandom_range(255)));
		end
	endtask

	// Mostly well-formed timestamps with random content; some damaged, cut short or noise.
	task automatic make_random_text();
		int r;
		int hdr_start;
		int cut;
		text_buf.delete();
		r = $urandom_range(99);
		if (r < 6) begin
			repeat ($urandom_range(30, 1)) text_buf.push_back(8'($urandom_range(255)));
			return;
		end
		repeat ($urandom_range(3)) text_buf.push_back(pick_blank());
		hdr_start = text_buf.size();
		put_num(($urandom_range(3) == 0) ? $urandom_range(9999) : $urandom_range(2100, 1900), 4);
		text_buf.push_back(CH_DASH);
		put_num(rand_field(1, 12), 2);
		text_buf.push_back(CH_DASH);
		put_num(rand_field(1, 31), 2);
		text_buf.push_back($urandom_range(1) ? CH_T : CH_SPACE);
		put_num(rand_field(0, 23), 2);
		text_buf.push_back(CH_COLON);
		put_num(rand_field(0, 59), 2);
		text_buf.push_back(CH_COLON);
		put_num(rand_field(0, 59), 2);
		if (r < 16) begin
			text_buf[hdr_start + $urandom_range(18)] = 8'($urandom_range(255));
		end else if (r < 22) begin
			cut = hdr_start + $urandom_range(18);
			while (text_buf.size() > cut) text_buf.delete(text_buf.size() - 1);
			repeat ($urandom_range(2)) text_buf.push_back(pick_blank());
			if (text_buf.size() == 0) text_buf.push_back(pick_blank());
			return;
		end
		case ($urandom_range(5))
			0: ;
			1: text_buf.push_back(CH_Z);
			2: begin
				text_buf.push_back(CH_DOT);
				repeat ($urandom_range(6, 1)) text_buf.push_back(pick_digit());
				case ($urandom_range(3))
					0: text_buf.push_back(CH_Z);
					1, 2: put_offset();
					default: text_buf.push_back(8'($urandom_range(255)));
				endcase
			end
			3, 4: put_offset();
			default: begin
				repeat ($urandom_range(5, 1)) text_buf.push_back(8'($urandom_range(255)));
			end
		endcase
		repeat ($urandom_range(2)) text_buf.push_back(pick_blank());
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		text_if.valid = 1'b0;
		text_if.text_byte = 8'h00;
		text_if.last_byte = 1'b0;
		result_if.ready = 1'b0;
		send_idle_pct = 31;
		recv_idle_pct = 57;
		words_sent = 0;
		texts_sent = 0;
		hold_pending = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed timestamps: field extremes, separators, fractions and offset corner cases.
		send_string("1970-01-01T00:00:00Z");
		send_string(" \011\0139999-99-99T99:99:99.123456-99:99 \015\012");
		send_string("0000-00-00 00:00:00+05:30");
		send_string("0000-01-01T00:00:00-00:01");
		send_string("2024-02-29T12:34:56+0");
		send_string("2024-02-29T12:34:56+ab:30");
		send_string("2024-02-29T12:34:56-05:3");
		send_string("2024-02-29T12:34:56+05 30\014");
		send_string("2024-02-29T12:34:56+01:00:77xyz");
		send_string("2024-02-29T12:34:56X+01:00");
		send_string("2024-02-29T12:34:56.99Q-03:00");
		send_string("2024-02-29T12:34");
		send_string(" \012 ");
		send_string("2024/02-29T12:34:56");
		send_string("2024-0a-29T12:34:56");
		send_string("2024-02-29T12:34:5 ");
		text_buf = '{8'hFF, 8'h80, CH_SLASH};
		send_text();

		// Random timestamps under three idling patterns, the last with a long output hold.
		while (words_sent < 600) begin
			make_random_text();
			send_text();
		end
		send_idle_pct = 57;
		recv_idle_pct = 31;
		while (words_sent < 1000) begin
			make_random_text();
			send_text();
		end
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_pending = 1'b1;
		while (words_sent < 1350) begin
			make_random_text();
			send_text();
		end
		text_if.valid <= 1'b0;

		// Drain the remaining results, then allow the pipeline to settle.
		while (sb.expected_epochs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Fed %0d text words forming %0d timestamps under three idling patterns.",
			words_sent, texts_sent);
		$display("Checked %0d accepted and %0d rejected timestamps; %0d mismatches.",
			sb.results_ok, sb.results_bad, sb.errors);
		if (sb.errors == 0 && sb.expected_epochs.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/r2e_pkg.sv
rtl/r2e_if.sv
rtl/r2e_dpath.sv
rtl/r2e_ctrl.sv
rtl/rfc3339_timestamp_to_epoch_unit.sv
test/tb_rfc3339_timestamp_to_epoch_unit.sv
